FILE: design/line_segment_clipper_unit_defines.svh
// Assertion macros shared by the clipper modules.
`ifndef LINE_SEGMENT_CLIPPER_UNIT_DEFINES_SVH
`define LINE_SEGMENT_CLIPPER_UNIT_DEFINES_SVH

// Assert that a condition holds at every clock edge outside reset.
`define LSC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Assert that an antecedent implies a consequent in the following cycle.
`define LSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lsc_pkg.sv
package lsc_pkg;

    // Coordinate width; the ports, the window registers and the datapath all follow it.
    localparam int COORD_BITS = 16;

    // Reset window edges: plus and minus one half in Q2.14.
    localparam logic signed [COORD_BITS-1:0] WIN_HALF = COORD_BITS'(1 << (COORD_BITS - 3));

    localparam logic [3:0] OC_LEFT   = 4'd1;
    localparam logic [3:0] OC_RIGHT  = 4'd2;
    localparam logic [3:0] OC_BOTTOM = 4'd4;
    localparam logic [3:0] OC_TOP    = 4'd8;

    localparam int MAX_PASSES = 4;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_MUL,
        ST_DIV,
        ST_APPLY,
        ST_DONE
    } lsc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic div_start;
        logic apply;
    } lsc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trivial_acc;
        logic trivial_rej;
        logic div_done;
    } lsc_status_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } lsc_in_t;

    typedef struct packed {
        logic                         accepted;
        logic signed [COORD_BITS-1:0] clip_start_x;
        logic signed [COORD_BITS-1:0] clip_start_y;
        logic signed [COORD_BITS-1:0] clip_end_x;
        logic signed [COORD_BITS-1:0] clip_end_y;
    } lsc_out_t;

endpackage

FILE: design/line_segment_clipper_unit.sv
// A segment that needs no clipping is done after its test; otherwise each clip pass (at most
// four) runs multiply, divide and apply before the segment is tested again.
// Throughput: one segment at a time; the one-bit-a-cycle divider sets the pace.
// Reset: asynchronous, active low; the window returns to plus or minus one half.
// The result word is shown for one cycle with done high; the receiver cannot stall.
`include "line_segment_clipper_unit_defines.svh"

module line_segment_clipper_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  lsc_pkg::lsc_in_t               in_word,
    output logic                           done,
    output lsc_pkg::lsc_out_t              out_word,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [lsc_pkg::COORD_BITS-1:0] cfg_data
);

    // Window registers; user writes via the configuration port only while idle, unenforced.
    logic signed [lsc_pkg::COORD_BITS-1:0] win_left_reg, win_right_reg;
    logic signed [lsc_pkg::COORD_BITS-1:0] win_bottom_reg, win_top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= -lsc_pkg::WIN_HALF;
            win_right_reg  <= lsc_pkg::WIN_HALF;
            win_bottom_reg <= -lsc_pkg::WIN_HALF;
            win_top_reg    <= lsc_pkg::WIN_HALF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsc_pkg::REG_LEFT:   win_left_reg   <= cfg_data;
                lsc_pkg::REG_RIGHT:  win_right_reg  <= cfg_data;
                lsc_pkg::REG_BOTTOM: win_bottom_reg <= cfg_data;
                lsc_pkg::REG_TOP:    win_top_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    lsc_pkg::lsc_cmd_t                     cmd;
    lsc_pkg::lsc_status_t                  status;
    logic                                  acc;
    logic signed [lsc_pkg::COORD_BITS-1:0] x0, y0, x1, y1;

    // The controller sequences test, multiply, divide and apply for each pass.
    lsc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .acc    (acc)
    );

    lsc_datapath #(.COORD_BITS(lsc_pkg::COORD_BITS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_x0      (in_word.start_x),
        .in_y0      (in_word.start_y),
        .in_x1      (in_word.end_x),
        .in_y1      (in_word.end_y),
        .win_left   (win_left_reg),
        .win_right  (win_right_reg),
        .win_bottom (win_bottom_reg),
        .win_top    (win_top_reg),
        .status     (status),
        .x0         (x0),
        .y0         (y0),
        .x1         (x1),
        .y1         (y1)
    );

    // A rejected segment reports zero endpoints.
    always_comb
    begin
        out_word.accepted     = acc;
        out_word.clip_start_x = acc ? x0 : '0;
        out_word.clip_start_y = acc ? y0 : '0;
        out_word.clip_end_x   = acc ? x1 : '0;
        out_word.clip_end_y   = acc ? y1 : '0;
    end

    `LSC_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy,
        "block still busy after delivering a word")
    `LSC_ASSERT_ALWAYS(a_done_busy, clk, rst_n, !done || busy,
        "result word shown while idle")
    `LSC_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy,
        "accepted segment did not start work")

endmodule

FILE: design/lsc_ctrl.sv
module lsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  lsc_pkg::lsc_status_t status,
    output lsc_pkg::lsc_cmd_t    cmd,
    output logic                 busy,
    output logic                 done,
    output logic                 acc
);

    lsc_pkg::lsc_state_t state_reg, state_next;
    logic [2:0] pass_reg, pass_next;
    logic acc_reg, acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsc_pkg::ST_IDLE;
            pass_reg  <= '0;
            acc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            acc_reg   <= acc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        acc_next   = acc_reg;
        cmd        = '0;
        done       = 1'b0;
        unique case (state_reg)
            lsc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    pass_next  = '0;
                    state_next = lsc_pkg::ST_TEST;
                end
            end
            lsc_pkg::ST_TEST:
            begin
                if (status.trivial_acc)
                begin
                    acc_next   = 1'b1;
                    state_next = lsc_pkg::ST_DONE;
                end
                else if (status.trivial_rej || pass_reg == 3'(lsc_pkg::MAX_PASSES))
                begin
                    acc_next   = 1'b0;
                    state_next = lsc_pkg::ST_DONE;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = lsc_pkg::ST_MUL;
                end
            end
            lsc_pkg::ST_MUL:
            begin
                cmd.div_start = 1'b1;
                state_next    = lsc_pkg::ST_DIV;
            end
            lsc_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = lsc_pkg::ST_APPLY;
                end
            end
            lsc_pkg::ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                pass_next  = pass_reg + 3'd1;
                state_next = lsc_pkg::ST_TEST;
            end
            lsc_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = lsc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lsc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != lsc_pkg::ST_IDLE);
    assign acc  = acc_reg;

endmodule

FILE: design/lsc_datapath.sv
`include "line_segment_clipper_unit_defines.svh"

module lsc_datapath #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lsc_pkg::lsc_cmd_t            cmd,
    input  logic signed [COORD_BITS-1:0] in_x0,
    input  logic signed [COORD_BITS-1:0] in_y0,
    input  logic signed [COORD_BITS-1:0] in_x1,
    input  logic signed [COORD_BITS-1:0] in_y1,
    input  logic signed [COORD_BITS-1:0] win_left,
    input  logic signed [COORD_BITS-1:0] win_right,
    input  logic signed [COORD_BITS-1:0] win_bottom,
    input  logic signed [COORD_BITS-1:0] win_top,
    output lsc_pkg::lsc_status_t         status,
    output logic signed [COORD_BITS-1:0] x0,
    output logic signed [COORD_BITS-1:0] y0,
    output logic signed [COORD_BITS-1:0] x1,
    output logic signed [COORD_BITS-1:0] y1
);

    localparam int DB = COORD_BITS + 1;      // differences
    localparam int PB = 2 * DB;              // product magnitude
    localparam int CB = $clog2(PB + 1);

    logic signed [COORD_BITS-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [3:0] c0, c1, co;

    function automatic logic [3:0] outcode(
        input logic signed [COORD_BITS-1:0] x,
        input logic signed [COORD_BITS-1:0] y,
        input logic signed [COORD_BITS-1:0] l,
        input logic signed [COORD_BITS-1:0] r,
        input logic signed [COORD_BITS-1:0] b,
        input logic signed [COORD_BITS-1:0] t
    );
        logic [3:0] c;
        c = '0;
        if (x < l) c = c | lsc_pkg::OC_LEFT;
        else if (x > r) c = c | lsc_pkg::OC_RIGHT;
        if (y < b) c = c | lsc_pkg::OC_BOTTOM;
        else if (y > t) c = c | lsc_pkg::OC_TOP;
        return c;
    endfunction

    assign c0 = outcode(x0_reg, y0_reg, win_left, win_right, win_bottom, win_top);
    assign c1 = outcode(x1_reg, y1_reg, win_left, win_right, win_bottom, win_top);
    assign co = (c0 != 4'd0) ? c0 : c1;

    assign status.trivial_acc = ((c0 | c1) == 4'd0);
    assign status.trivial_rej = ((c0 & c1) != 4'd0);

    // Operand selection for the interpolation.
    logic signed [DB-1:0] num, eoff, den;
    logic signed [COORD_BITS-1:0] base, edge_v;
    logic vert;

    always_comb
    begin
        vert = ((co & (lsc_pkg::OC_TOP | lsc_pkg::OC_BOTTOM)) != 4'd0);
        priority if ((co & lsc_pkg::OC_TOP) != 4'd0)
            edge_v = win_top;
        else if ((co & lsc_pkg::OC_BOTTOM) != 4'd0)
            edge_v = win_bottom;
        else if ((co & lsc_pkg::OC_RIGHT) != 4'd0)
            edge_v = win_right;
        else
            edge_v = win_left;
        if (vert)
        begin
            base = x0_reg;
            num  = DB'(x1_reg) - DB'(x0_reg);
            eoff = DB'(edge_v) - DB'(y0_reg);
            den  = DB'(y1_reg) - DB'(y0_reg);
        end
        else
        begin
            base = y0_reg;
            num  = DB'(y1_reg) - DB'(y0_reg);
            eoff = DB'(edge_v) - DB'(x0_reg);
            den  = DB'(x1_reg) - DB'(x0_reg);
        end
    end

    // Registered pass operands.
    logic [PB-1:0]                prod_reg;
    logic [DB-1:0]                den_reg;
    logic                         neg_reg, vert_reg, sel0_reg, zero_reg;
    logic signed [COORD_BITS-1:0] base_reg, edge_reg;

    // Restoring divider: one quotient bit a cycle.
    logic [PB-1:0] quo_reg, quo_next;
    logic [DB:0]   rem_reg, rem_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic [DB:0]   trial;

    always_comb
    begin
        trial    = {rem_reg[DB-1:0], quo_reg[PB-1]};
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (cmd.div_start)
        begin
            quo_next = prod_reg;
            rem_next = '0;
            cnt_next = CB'(PB);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[PB-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[PB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CB'(1);
            if (cnt_reg == CB'(1))
                run_next = 1'b0;
        end
    end

    assign status.div_done = run_reg && (cnt_reg == CB'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    logic [DB-1:0] mag_num, mag_eoff, mag_den;
    assign mag_num  = num[DB-1]  ? DB'(-num)  : DB'(num);
    assign mag_eoff = eoff[DB-1] ? DB'(-eoff) : DB'(eoff);
    assign mag_den  = den[DB-1]  ? DB'(-den)  : DB'(den);

    // Interpolated coordinate with saturation.
    localparam int SB = PB + 2;
    logic signed [SB-1:0] sum, cmax, cmin;
    logic signed [COORD_BITS-1:0] newc;

    always_comb
    begin
        cmax = SB'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
        cmin = -cmax - SB'(1);
        if (neg_reg)
            sum = SB'(base_reg) - SB'({1'b0, quo_reg});
        else
            sum = SB'(base_reg) + SB'({1'b0, quo_reg});
        if (zero_reg)
            newc = base_reg;
        else if (sum > cmax)
            newc = cmax[COORD_BITS-1:0];
        else if (sum < cmin)
            newc = cmin[COORD_BITS-1:0];
        else
            newc = sum[COORD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.mul)
        begin
            prod_reg <= mag_num * mag_eoff;
            den_reg  <= mag_den;
            zero_reg <= (den == '0);
            neg_reg  <= (num[DB-1] ^ eoff[DB-1]) ^ den[DB-1];
            vert_reg <= vert;
            sel0_reg <= (c0 != 4'd0);
            base_reg <= base;
            edge_reg <= edge_v;
        end
        if (cmd.load)
        begin
            x0_reg <= in_x0;
            y0_reg <= in_y0;
            x1_reg <= in_x1;
            y1_reg <= in_y1;
        end
        else if (cmd.apply)
        begin
            if (sel0_reg)
            begin
                x0_reg <= vert_reg ? newc : edge_reg;
                y0_reg <= vert_reg ? edge_reg : newc;
            end
            else
            begin
                x1_reg <= vert_reg ? newc : edge_reg;
                y1_reg <= vert_reg ? edge_reg : newc;
            end
        end
    end

    assign x0 = x0_reg;
    assign y0 = y0_reg;
    assign x1 = x1_reg;
    assign y1 = y1_reg;

    `LSC_ASSERT_NEXT(a_div_ends, clk, rst_n, status.div_done, !run_reg,
        "divider still running after its last step")
    `LSC_ASSERT_ALWAYS(a_no_start_while_run, clk, rst_n, !(cmd.div_start && run_reg),
        "division started while another runs")
    `LSC_ASSERT_ALWAYS(a_apply_idle_div, clk, rst_n, !(cmd.apply && run_reg),
        "result applied before the division finished")

endmodule
